>>> rtl/core/rkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rkc_pkg;

  // Default temperature format, unsigned Q12.20 kelvin
  localparam int TEMP_WIDTH_DEF = 32;
  localparam int TEMP_FRAC_DEF  = 20;

  // Multiplier digit consumed by one cell of a multiply chain
  localparam int DIGIT_W = 16;

  // Register widths
  localparam int COEF_W   = 48;
  localparam int STEP_W   = 32;
  localparam int HEAT_W   = 63;
  localparam int ENERGY_W = 64;

  // Coefficient times step, formed in two halves
  localparam int COEF_SPLIT = 24;
  localparam int K_W        = COEF_W + STEP_W;

  // Binary scaling of the coefficient and of the time step
  localparam int COEF_FRAC = 80;
  localparam int STEP_FRAC = 16;

  localparam logic [COEF_W-1:0] COEF_RESET = '0;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [HEAT_W-1:0] HEAT_RESET = HEAT_W'(1);

  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF = 2'd0,
    REG_STEP = 2'd1,
    REG_HEAT = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

>>> rtl/core/rkc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rkc_sample_if import rkc_pkg::*; #(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [TEMP_WIDTH-1:0] start_temperature;

  modport source (output valid, output start_temperature, input ready);
  modport sink   (input valid, input start_temperature, output ready);
endinterface

interface rkc_result_if import rkc_pkg::*; #(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [TEMP_WIDTH-1:0] end_temperature;
  logic [ENERGY_W-1:0]   radiated_energy;
  logic                  clamped;

  modport source (output valid, output end_temperature, output radiated_energy,
                  output clamped, input ready);
  modport sink   (input valid, input end_temperature, input radiated_energy,
                  input clamped, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rkc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One multiply-accumulate cell: shift the running product up one digit and
// add the multiplicand times the top digit of the multiplier.
module rkc_cell import rkc_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int PW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [AW-1:0] in_a,
  input  logic [BW-1:0] in_b,
  input  logic [PW-1:0] in_acc,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [AW-1:0] out_a,
  output logic [BW-1:0] out_b,
  output logic [PW-1:0] out_acc,
  output logic [SW-1:0] out_side
);

  logic [DIGIT_W-1:0]    digit;
  logic [AW+DIGIT_W-1:0] part;
  logic [PW-1:0]         acc_next;

  always_comb begin
    digit    = in_b[BW-1 -: DIGIT_W];
    part     = in_a * digit;
    acc_next = (in_acc << DIGIT_W) + PW'(part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a    <= in_a;
      out_b    <= in_b << DIGIT_W;
      out_acc  <= acc_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rkc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Multiplier built as a row of cells, one multiplier digit per cell, MSB first.
module rkc_mul import rkc_pkg::*; #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  input  logic [SW-1:0]    side,
  output logic             out_valid,
  output logic [AW+BW-1:0] p,
  output logic [SW-1:0]    side_out
);

  localparam int NC  = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BPW = NC * DIGIT_W;
  localparam int PW  = AW + BPW;

  logic           v_s   [NC+1];
  logic [AW-1:0]  a_s   [NC+1];
  logic [BPW-1:0] b_s   [NC+1];
  logic [PW-1:0]  acc_s [NC+1];
  logic [SW-1:0]  sd_s  [NC+1];

  assign v_s[0]   = in_valid;
  assign a_s[0]   = a;
  assign b_s[0]   = BPW'(b);
  assign acc_s[0] = '0;
  assign sd_s[0]  = side;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rkc_cell #(.AW(AW), .BW(BPW), .PW(PW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_s[i]),
      .in_a     (a_s[i]),
      .in_b     (b_s[i]),
      .in_acc   (acc_s[i]),
      .in_side  (sd_s[i]),
      .out_valid(v_s[i+1]),
      .out_a    (a_s[i+1]),
      .out_b    (b_s[i+1]),
      .out_acc  (acc_s[i+1]),
      .out_side (sd_s[i+1])
    );
  end

  assign out_valid = v_s[NC];
  assign p         = acc_s[NC][AW+BW-1:0];
  assign side_out  = sd_s[NC];

endmodule

`default_nettype wire

>>> rtl/core/rkc_slope.sv
`timescale 1ns / 1ps
`default_nettype none

// Scaled cooling slope h(x) = floor(K * x^4 / 2^SHIFT), saturated to XW bits.
module rkc_slope import rkc_pkg::*; #(
  parameter int XW        = 35,
  parameter int FRAC_BITS = 20,
  parameter int SW        = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [XW-1:0]  x,
  input  logic [SW-1:0]  side,
  input  logic [K_W-1:0] k,
  output logic           out_valid,
  output logic [XW-1:0]  h,
  output logic [SW-1:0]  side_out
);

  localparam int SHIFT = COEF_FRAC + STEP_FRAC + 3 * FRAC_BITS;
  localparam int QW    = 4 * XW + K_W;

  logic          v0;
  logic [XW-1:0] x0;
  logic [SW-1:0] s0;

  logic            v2;
  logic [2*XW-1:0] x2;
  logic [SW-1:0]   s2;
  logic            v4;
  logic [4*XW-1:0] x4;
  logic [SW-1:0]   s4;
  logic            vq;
  logic [QW-1:0]   q;
  logic [SW-1:0]   sq;

  logic [QW-1:0] q_top;
  logic [XW-1:0] h_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= x;
      s0 <= side;
    end
  end

  rkc_mul #(.AW(XW), .BW(XW), .SW(SW)) u_sq (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .a(x0), .b(x0), .side(s0),
    .out_valid(v2), .p(x2), .side_out(s2)
  );

  rkc_mul #(.AW(2*XW), .BW(2*XW), .SW(SW)) u_quad (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .a(x2), .b(x2), .side(s2),
    .out_valid(v4), .p(x4), .side_out(s4)
  );

  rkc_mul #(.AW(4*XW), .BW(K_W), .SW(SW)) u_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4), .a(x4), .b(k), .side(s4),
    .out_valid(vq), .p(q), .side_out(sq)
  );

  always_comb begin
    q_top  = q >> SHIFT;
    h_next = (|(q_top >> XW)) ? '1 : q_top[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h        <= h_next;
      side_out <= sq;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/radiative_cooling_rk4_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One RK4 step of radiative cooling dT/dt = -c*T^4 per request, fully pipelined:
// a new temperature is taken every cycle while the pipeline is not held, and
// each result passes through the four slope evaluations in a row;
// each evaluation squares, squares again and scales by coefficient times
// step in chains of 16-bit digit cells, so depth grows with TEMP_WIDTH. The
// coefficient-times-step product is re-formed in k_lo and k_hi, then in k,
// after a register write. A two-entry result buffer lets the pipeline keep moving
// while one finished result waits; the whole pipeline holds only when it is full.
// A step that would drive the temperature below zero returns zero with the
// clamped flag set; the energy is always the real drop times heat capacity,
// shifted right by TEMP_FRAC_BITS and saturated to 64 bits.
module radiative_cooling_rk4_step import rkc_pkg::*; #(
  parameter int TEMP_WIDTH     = TEMP_WIDTH_DEF,
  parameter int TEMP_FRAC_BITS = TEMP_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  rkc_sample_if.sink           sample,
  rkc_result_if.source         result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [HEAT_W-1:0]    wr_data
);

  localparam int W    = TEMP_WIDTH;
  localparam int XW   = TEMP_WIDTH + 3;   // slope and stage-temperature width
  localparam int SUMW = XW + 3;           // weighted slope sum
  localparam int NW   = SUMW - 1;         // half sum, fed to divide by three
  localparam int EPW  = HEAT_W + TEMP_WIDTH;
  localparam int FIFO_DEPTH = 2;
  // floor(n/3) = (n * DIV_M) >> SUMW for any NW-bit n
  localparam logic [63:0] DIV_M_FULL = ((64'd1 << SUMW) + 64'd2) / 64'd3;
  localparam logic [NW-1:0] DIV_M = DIV_M_FULL[NW-1:0];

  typedef struct packed {
    logic [W-1:0]        end_t;
    logic [ENERGY_W-1:0] energy;
    logic                clamped;
  } res_t;

  function automatic logic [XW-1:0] abs_diff(logic [XW-1:0] p, logic [XW-1:0] q);
    return (p > q) ? (p - q) : (q - p);
  endfunction

  // Configuration registers
  logic [COEF_W-1:0] coef;
  logic [STEP_W-1:0] step;
  logic [HEAT_W-1:0] heat;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
      step <= STEP_RESET;
      heat <= HEAT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_COEF: coef <= wr_data[COEF_W-1:0];
        REG_STEP: step <= wr_data[STEP_W-1:0];
        REG_HEAT: heat <= wr_data;
        default:  ;
      endcase
    end
  end

  // Coefficient times step, two halves then the sum
  logic [COEF_SPLIT+STEP_W-1:0]        k_lo;
  logic [COEF_W-COEF_SPLIT+STEP_W-1:0] k_hi;
  logic [K_W-1:0]                      k;

  always_ff @(posedge clk) begin
    k_lo <= coef[COEF_SPLIT-1:0] * step;
    k_hi <= coef[COEF_W-1:COEF_SPLIT] * step;
    k    <= (K_W'(k_hi) << COEF_SPLIT) + K_W'(k_lo);
  end

  // Global advance: hold everything only while the result buffer is full
  // and the consumer is not taking a result.
  logic [1:0] count;
  logic       en;
  logic       push;
  logic       pop;

  assign en           = (count != 2'(FIFO_DEPTH)) || result.ready;
  assign sample.ready = en;

  // Four slope evaluations
  logic            v1, v2, v3, v4;
  logic [XW-1:0]   h1, h2, h3, h4;
  logic [W-1:0]    t1, t2, t3, t4;
  logic [SUMW-1:0] acc2, acc3, acc4;

  logic [XW-1:0]     x2, x3, x4;
  logic [W+SUMW-1:0] side2, side3, side4;

  always_comb begin
    x2    = abs_diff(XW'(t1), h1 >> 1);
    side2 = {t1, SUMW'(h1)};
    x3    = abs_diff(XW'(t2), h2 >> 1);
    side3 = {t2, acc2 + (SUMW'(h2) << 1)};
    x4    = abs_diff(XW'(t3), h3);
    side4 = {t3, acc3 + (SUMW'(h3) << 1)};
  end

  rkc_slope #(.XW(XW), .FRAC_BITS(TEMP_FRAC_BITS), .SW(W)) u_k1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(sample.valid),
    .x(XW'(sample.start_temperature)), .side(sample.start_temperature), .k(k),
    .out_valid(v1), .h(h1), .side_out(t1)
  );

  rkc_slope #(.XW(XW), .FRAC_BITS(TEMP_FRAC_BITS), .SW(W+SUMW)) u_k2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .x(x2), .side(side2), .k(k),
    .out_valid(v2), .h(h2), .side_out({t2, acc2})
  );

  rkc_slope #(.XW(XW), .FRAC_BITS(TEMP_FRAC_BITS), .SW(W+SUMW)) u_k3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .x(x3), .side(side3), .k(k),
    .out_valid(v3), .h(h3), .side_out({t3, acc3})
  );

  rkc_slope #(.XW(XW), .FRAC_BITS(TEMP_FRAC_BITS), .SW(W+SUMW)) u_k4 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .x(x4), .side(side4), .k(k),
    .out_valid(v4), .h(h4), .side_out({t4, acc4})
  );

  // Close the weighted sum and halve it; divide by three follows
  logic          vs;
  logic [NW-1:0] half_sum;
  logic [W-1:0]  ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_sum <= NW'((acc4 + SUMW'(h4)) >> 1);
      ts       <= t4;
    end
  end

  logic            vd;
  logic [2*NW-1:0] prod_d;
  logic [W-1:0]    td;

  rkc_mul #(.AW(NW), .BW(NW), .SW(W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vs), .a(half_sum), .b(DIV_M),
    .side(ts), .out_valid(vd), .p(prod_d), .side_out(td)
  );

  // Clamp at zero; the real drop is T itself when clamped
  logic [SUMW-1:0] drop;
  logic            vc;
  logic [W-1:0]    endt_c;
  logic [W-1:0]    act_c;
  logic            clamp_c;

  assign drop = SUMW'(prod_d >> SUMW);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (drop > SUMW'(td)) begin
        endt_c  <= '0;
        act_c   <= td;
        clamp_c <= 1'b1;
      end else begin
        endt_c  <= td - W'(drop);
        act_c   <= W'(drop);
        clamp_c <= 1'b0;
      end
    end
  end

  // Energy: drop times heat capacity
  logic           ve;
  logic [EPW-1:0] prod_e;
  logic [W-1:0]   endt_e;
  logic           clamp_e;
  logic [EPW-1:0] e_sh;
  res_t           res_next;

  rkc_mul #(.AW(HEAT_W), .BW(W), .SW(W+1)) u_energy (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc), .a(heat), .b(act_c),
    .side({endt_c, clamp_c}), .out_valid(ve), .p(prod_e), .side_out({endt_e, clamp_e})
  );

  always_comb begin
    e_sh             = prod_e >> TEMP_FRAC_BITS;
    res_next.end_t   = endt_e;
    res_next.energy  = (|(e_sh >> ENERGY_W)) ? '1 : e_sh[ENERGY_W-1:0];
    res_next.clamped = clamp_e;
  end

  // Two-entry result buffer
  res_t fifo_mem [FIFO_DEPTH];
  logic wr_ptr;
  logic rd_ptr;

  assign push = ve && en;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res_next;
    end
  end

  assign result.valid           = (count != '0);
  assign result.end_temperature = fifo_mem[rd_ptr].end_t;
  assign result.radiated_energy = fifo_mem[rd_ptr].energy;
  assign result.clamped         = fifo_mem[rd_ptr].clamped;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.clamped) |-> (result.end_temperature == '0))
    else $error("clamped result with nonzero temperature");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> (count == 2'(FIFO_DEPTH)))
    else $error("result buffer count lost a request");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(FIFO_DEPTH) && !result.ready) |-> !push)
    else $error("push into full result buffer");

endmodule

`default_nettype wire
